// ===== hdl/heightmap_directional_smoothing_core_assert.svh =====
`ifndef HEIGHTMAP_DIRECTIONAL_SMOOTHING_CORE_ASSERT_SVH
`define HEIGHTMAP_DIRECTIONAL_SMOOTHING_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define HDS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define HDS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/hds_pkg.sv =====
package hds_pkg;

  localparam int GRID_SIZE = 129;
  localparam int GRID_MAX  = GRID_SIZE - 1;
  localparam int IDX_W     = $clog2(GRID_SIZE);
  localparam int DEPTH     = GRID_SIZE * GRID_SIZE;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int RC_W      = 8;
  localparam int ADDR_IN_W = (IDX_W > RC_W) ? IDX_W : RC_W;

  localparam int H_W  = 24;
  localparam int K_W  = 17;
  localparam int PC_W = 8;

  localparam logic [K_W-1:0] K_ONE = K_W'(65536);
  localparam logic [K_W-1:0] K_RESET = K_W'(32768);

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_RUN   = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_FACTOR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PASS_COUNT    = 1'b1;

  typedef enum logic [1:0] {
    PASS_ROW_UP = 2'd0,
    PASS_ROW_DN = 2'd1,
    PASS_COL_UP = 2'd2,
    PASS_COL_DN = 2'd3
  } pass_t;

  typedef struct packed {
    logic cap_nb;
    logic mul_own;
    logic mul_nb;
  } blend_ctl_t;

  typedef struct packed {
    logic [ADDR_W-1:0] own_addr;
    logic [ADDR_W-1:0] nb_addr;
    logic              last;
  } seq_pos_t;

  function automatic logic [ADDR_W-1:0] grid_addr(input logic [ADDR_IN_W-1:0] x,
                                                  input logic [ADDR_IN_W-1:0] z);
    grid_addr = ADDR_W'(x) * ADDR_W'(GRID_SIZE) + ADDR_W'(z);
  endfunction

endpackage

// ===== hdl/hds_store.sv =====
module hds_store
  import hds_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [H_W-1:0]    wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [H_W-1:0]    rdata
);

  logic [H_W-1:0] mem [DEPTH];
  logic [H_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/hds_blend.sv =====
module hds_blend
  import hds_pkg::*;
(
  input  logic                  clk,
  input  blend_ctl_t            ctl,
  input  logic [K_W-1:0]        smooth_factor,
  input  logic signed [H_W-1:0] din,
  output logic signed [H_W-1:0] result
);

  localparam int P_W = H_W + K_W;
  localparam int S_W = P_W + 1;
  localparam int Q_W = S_W - 16;
  localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(8388607);
  localparam logic signed [Q_W-1:0] Q_MIN = -Q_W'(8388608);

  logic [K_W-1:0]        k_eff;
  logic [K_W-1:0]        k_inv;
  logic signed [H_W-1:0] nb_r;
  logic signed [H_W-1:0] op_a;
  logic signed [K_W:0]   op_b;
  logic signed [S_W-1:0] prod_full;
  logic [P_W-1:0]        prod_r;
  logic [P_W-1:0]        acc_r;
  logic [S_W-1:0]        sum;
  logic signed [Q_W-1:0] q;

  assign k_eff = (smooth_factor > K_ONE) ? K_ONE : smooth_factor;
  assign k_inv = K_ONE - k_eff;

  // one multiplier, used for own*k and then neighbour*(1-k)
  assign op_a      = ctl.mul_nb ? nb_r : din;
  assign op_b      = $signed({1'b0, (ctl.mul_nb ? k_inv : k_eff)});
  assign prod_full = op_a * op_b;

  always_ff @(posedge clk) begin
    if (ctl.cap_nb) begin
      nb_r <= din;
    end
    if (ctl.mul_own || ctl.mul_nb) begin
      prod_r <= prod_full[P_W-1:0];
    end
    if (ctl.mul_nb) begin
      acc_r <= prod_r;
    end
  end

  // upper bits of the sum give the floored quotient by 65536
  assign sum = {acc_r[P_W-1], acc_r} + {prod_r[P_W-1], prod_r};
  assign q   = $signed(sum[S_W-1:16]);

  always_comb begin
    if (q > Q_MAX) begin
      result = H_W'(Q_MAX);
    end else if (q < Q_MIN) begin
      result = H_W'(Q_MIN);
    end else begin
      result = q[H_W-1:0];
    end
  end

endmodule

// ===== hdl/hds_seq.sv =====
module hds_seq
  import hds_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic            step,
  input  logic [PC_W-1:0] pass_count,
  output seq_pos_t        pos
);

  localparam logic [IDX_W-1:0] I_ONE  = IDX_W'(1);
  localparam logic [IDX_W-1:0] I_TWO  = IDX_W'(2);
  localparam logic [IDX_W-1:0] I_HI   = IDX_W'(GRID_MAX - 1);
  localparam logic [IDX_W-1:0] I_HI2  = IDX_W'(GRID_MAX - 2);

  logic [IDX_W-1:0] x_r, x_nxt;
  logic [IDX_W-1:0] z_r, z_nxt;
  pass_t            pass_r, pass_nxt;
  logic [PC_W-1:0]  rep_r, rep_nxt;
  pass_t            pass_next;
  logic [IDX_W-1:0] lx, lz;
  logic [IDX_W-1:0] nx, nz;

  function automatic logic [IDX_W-1:0] first_x(input pass_t p);
    case (p)
      PASS_ROW_UP: first_x = I_TWO;
      PASS_ROW_DN: first_x = I_HI2;
      default:     first_x = I_ONE;
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] first_z(input pass_t p);
    case (p)
      PASS_COL_UP: first_z = I_TWO;
      PASS_COL_DN: first_z = I_HI;
      default:     first_z = I_ONE;
    endcase
  endfunction

  always_comb begin
    case (pass_r)
      PASS_ROW_UP: pass_next = PASS_ROW_DN;
      PASS_ROW_DN: pass_next = PASS_COL_UP;
      PASS_COL_UP: pass_next = PASS_COL_DN;
      default:     pass_next = PASS_ROW_UP;
    endcase
  end

  assign lx = (pass_r == PASS_ROW_DN) ? I_ONE : I_HI;
  assign lz = (pass_r == PASS_COL_DN) ? I_ONE : I_HI;

  always_comb begin
    nx = x_r;
    nz = z_r;
    case (pass_r)
      PASS_ROW_UP: nx = x_r - I_ONE;
      PASS_ROW_DN: nx = x_r + I_ONE;
      PASS_COL_UP: nz = z_r - I_ONE;
      default:     nz = z_r + I_ONE;
    endcase
  end

  always_comb begin
    x_nxt    = x_r;
    z_nxt    = z_r;
    pass_nxt = pass_r;
    rep_nxt  = rep_r;
    if (start) begin
      pass_nxt = PASS_ROW_UP;
      x_nxt    = first_x(PASS_ROW_UP);
      z_nxt    = first_z(PASS_ROW_UP);
      rep_nxt  = '0;
    end else if (step) begin
      if (z_r != lz) begin
        z_nxt = (pass_r == PASS_COL_DN) ? z_r - I_ONE : z_r + I_ONE;
      end else if (x_r != lx) begin
        z_nxt = first_z(pass_r);
        x_nxt = (pass_r == PASS_ROW_DN) ? x_r - I_ONE : x_r + I_ONE;
      end else begin
        // sweep finished, move on to the next direction
        pass_nxt = pass_next;
        x_nxt    = first_x(pass_next);
        z_nxt    = first_z(pass_next);
        if (pass_r == PASS_COL_DN) begin
          rep_nxt = rep_r + PC_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r    <= '0;
      z_r    <= '0;
      pass_r <= PASS_ROW_UP;
      rep_r  <= '0;
    end else begin
      x_r    <= x_nxt;
      z_r    <= z_nxt;
      pass_r <= pass_nxt;
      rep_r  <= rep_nxt;
    end
  end

  assign pos.own_addr = grid_addr(ADDR_IN_W'(x_r), ADDR_IN_W'(z_r));
  assign pos.nb_addr  = grid_addr(ADDR_IN_W'(nx), ADDR_IN_W'(nz));
  assign pos.last     = (pass_r == PASS_COL_DN) && (x_r == lx) && (z_r == lz)
                        && (rep_r == pass_count);

endmodule

// ===== hdl/heightmap_directional_smoothing_core.sv =====
// Height grid smoother. A write beat stores one Q12.12 sample and leaves the block ready
// in the next cycle; a read beat moves the block to a read state that loads the result
// into the output register once the output is free and then returns to idle. A run beat
// smooths the grid interior in place and then returns one result with run_done set and a
// zero height. Every touched sample passes in order through the single read port of the
// grid memory and the one shared multiplier (read neighbour, read own, two products,
// write back), and the four directional sweeps are repeated pass_count + 1 times. The
// grid memory is not cleared: only written samples may be read or smoothed.
module heightmap_directional_smoothing_core
  import hds_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_req_type,
  input  logic [RC_W-1:0]       in_row,
  input  logic [RC_W-1:0]       in_col,
  input  logic signed [H_W-1:0] in_height_in,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [H_W-1:0] out_height_out,
  output logic                  out_run_done,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [K_W-1:0]        cfg_wdata
);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_RD_OUT = 8'b0000_0010,
    ST_RD_NB  = 8'b0000_0100,
    ST_RD_OWN = 8'b0000_1000,
    ST_MUL_A  = 8'b0001_0000,
    ST_MUL_B  = 8'b0010_0000,
    ST_WR     = 8'b0100_0000,
    ST_DONE   = 8'b1000_0000
  } state_t;

  state_t            state_r, state_nxt;
  logic [K_W-1:0]    smooth_factor_r;
  logic [PC_W-1:0]   pass_count_r;
  logic [ADDR_W-1:0] addr_r;
  logic              inside_r;
  logic              out_valid_r;
  logic [H_W-1:0]    out_height_r;
  logic              out_run_done_r;

  logic              in_accept;
  logic              in_inside;
  logic [ADDR_W-1:0] in_addr;
  logic              out_free;
  logic              load_rd;
  logic              load_done;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [H_W-1:0]    mem_wdata;
  logic [ADDR_W-1:0] rd_addr;
  logic [H_W-1:0]    rd_data;
  blend_ctl_t        ctl;
  logic              seq_start;
  logic              seq_step;
  seq_pos_t          pos;
  logic signed [H_W-1:0] blend_res;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign in_inside = (32'(in_row) < GRID_SIZE) && (32'(in_col) < GRID_SIZE);
  assign in_addr   = grid_addr(ADDR_IN_W'(in_row), ADDR_IN_W'(in_col));
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    mem_we    = 1'b0;
    mem_waddr = in_addr;
    mem_wdata = in_height_in;
    rd_addr   = in_addr;
    ctl       = '0;
    seq_start = 1'b0;
    seq_step  = 1'b0;
    load_rd   = 1'b0;
    load_done = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          case (in_req_type)
            REQ_WRITE: mem_we = in_inside;
            REQ_READ:  state_nxt = ST_RD_OUT;
            REQ_RUN: begin
              seq_start = 1'b1;
              state_nxt = ST_RD_NB;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_RD_OUT: begin
        // keep addressing the sample so the read data holds while the output is busy
        rd_addr = addr_r;
        if (out_free) begin
          load_rd   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_RD_NB: begin
        rd_addr   = pos.nb_addr;
        state_nxt = ST_RD_OWN;
      end
      ST_RD_OWN: begin
        rd_addr    = pos.own_addr;
        ctl.cap_nb = 1'b1;
        state_nxt  = ST_MUL_A;
      end
      ST_MUL_A: begin
        ctl.mul_own = 1'b1;
        state_nxt   = ST_MUL_B;
      end
      ST_MUL_B: begin
        ctl.mul_nb = 1'b1;
        state_nxt  = ST_WR;
      end
      ST_WR: begin
        mem_we    = 1'b1;
        mem_waddr = pos.own_addr;
        mem_wdata = blend_res;
        seq_step  = 1'b1;
        state_nxt = pos.last ? ST_DONE : ST_RD_NB;
      end
      ST_DONE: begin
        if (out_free) begin
          load_done = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smooth_factor_r <= K_RESET;
      pass_count_r    <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_SMOOTH_FACTOR: smooth_factor_r <= cfg_wdata;
        REG_PASS_COUNT:    pass_count_r    <= cfg_wdata[PC_W-1:0];
        default:           pass_count_r    <= pass_count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      addr_r   <= in_addr;
      inside_r <= in_inside;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_rd || load_done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rd) begin
      out_height_r   <= inside_r ? rd_data : '0;
      out_run_done_r <= 1'b0;
    end else if (load_done) begin
      out_height_r   <= '0;
      out_run_done_r <= 1'b1;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_height_out = out_height_r;
  assign out_run_done   = out_run_done_r;

  hds_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  hds_blend u_blend (
    .clk           (clk),
    .ctl           (ctl),
    .smooth_factor (smooth_factor_r),
    .din           (rd_data),
    .result        (blend_res)
  );

  hds_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (seq_start),
    .step       (seq_step),
    .pass_count (pass_count_r),
    .pos        (pos)
  );

endmodule

// ===== hdl/hds_checker.sv =====
`include "heightmap_directional_smoothing_core_assert.svh"

module hds_checker
  import hds_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic [1:0]            in_req_type,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic signed [H_W-1:0] out_height_out,
  input logic                  out_run_done
);

  logic in_beat;

  assign in_beat = in_valid && !in_stall;

  // a held result keeps its payload
  `HDS_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_height_out) && $stable(out_run_done), "result changed while stalled")

  // run completion carries no height
  `HDS_ASSERT_NOW(a_done_zero, out_valid && out_run_done, out_height_out == '0,
    "run completion with nonzero height")

  // a write never blocks the next beat
  `HDS_ASSERT_NEXT(a_write_ready, in_beat && (in_req_type == REQ_WRITE), !in_stall,
    "write left the block busy")

  // a run or a read keeps the block busy for at least the next cycle
  `HDS_ASSERT_NEXT(a_busy_after, in_beat && ((in_req_type == REQ_RUN) || (in_req_type == REQ_READ)),
    in_stall, "block ready right after run or read")

endmodule

bind heightmap_directional_smoothing_core hds_checker u_hds_checker (.*);
